FILE: hdl/qenc_pkg.sv
// ----------------------------------------------------------------------------
// qenc_pkg
// Shared widths, codes and command types of the quadrature encoder counter.
// ----------------------------------------------------------------------------
package qenc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int CNT_W       = $clog2(COUNT_WIDTH);
  localparam int OUT_W       = 32;
  localparam int PPT_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_USE_X4 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PPT    = 8'd1;

  localparam logic [1:0] PHASE_BOTH = 2'h3;
  localparam logic [1:0] PHASE_NONE = 2'h0;
  localparam logic [1:0] PHASE_A    = 2'h2;
  localparam logic [1:0] PHASE_B    = 2'h1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic start;
    logic prep;
    logic step;
    logic load;
  } qenc_cmd_t;

endpackage

FILE: hdl/qenc_in_if.sv
// ----------------------------------------------------------------------------
// qenc_in_if
// Input channel: channel sample or clear command with valid/ready.
// ----------------------------------------------------------------------------
interface qenc_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic chan_a;
  logic chan_b;

  modport source (output valid, mode, chan_a, chan_b, input ready);
  modport sink   (input valid, mode, chan_a, chan_b, output ready);
endinterface

FILE: hdl/qenc_out_if.sv
// ----------------------------------------------------------------------------
// qenc_out_if
// Result channel: pulse count and revolutions with valid/ready.
// ----------------------------------------------------------------------------
interface qenc_out_if import qenc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pulse_total;
  logic signed [OUT_W-1:0] turns;

  modport source (output valid, pulse_total, turns, input ready);
  modport sink   (input valid, pulse_total, turns, output ready);
endinterface

FILE: hdl/qenc_cfg_if.sv
// ----------------------------------------------------------------------------
// qenc_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface qenc_cfg_if import qenc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/quadrature_encoder_counter_core.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_counter_core
// Quadrature decoder with X2/X4 modes, signed pulse count and revolutions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per transfer, a channel sample (mode 0) or a clear
//            command (mode 1). The first sample after reset only primes
//            the stored phase.
//   out_ch : one result per item: pulse_total and turns, the count divided
//            by pulses_per_turn and truncated toward zero.
//   cfg_ch : register writes, index 0 = use_x4, index 1 = pulses_per_turn,
//            always ready; write only while the block is idle.
// Timing: the count updates at the transfer edge; the magnitude is then formed,
//   the restoring divider runs one quotient bit a cycle, and the result is
//   loaded into the output register. in_ch is ready again in the cycle the
//   result appears, so the block takes no new item while one is in progress.
// Reset: synchronous, rst_n low; use_x4 = 1, pulses_per_turn = 1, count 0.
// Stall: a waiting result holds in the output register; the next item is
//   still taken and its result waits in the last step until out_ch frees.
// ----------------------------------------------------------------------------
module quadrature_encoder_counter_core import qenc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  qenc_in_if.sink   in_ch,
  qenc_out_if.source out_ch,
  qenc_cfg_if.sink  cfg_ch
);

  qenc_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  qenc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  qenc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_ch.mode),
    .in_chan_a       (in_ch.chan_a),
    .in_chan_b       (in_ch.chan_b),
    .cfg_write       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_pulse_total (out_ch.pulse_total),
    .out_turns       (out_ch.turns)
  );

endmodule

FILE: hdl/qenc_ctrl.sv
// ----------------------------------------------------------------------------
// qenc_ctrl
// Sequencer: accept, prepare magnitude, iterate the divider, load result.
// ----------------------------------------------------------------------------
module qenc_ctrl import qenc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output qenc_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(COUNT_WIDTH - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/qenc_dp.sv
// ----------------------------------------------------------------------------
// qenc_dp
// Datapath: configuration, phase decode, pulse count, restoring divider
// and output register.
// ----------------------------------------------------------------------------
module qenc_dp import qenc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qenc_cmd_t               cmd,
  input  logic                    in_mode,
  input  logic                    in_chan_a,
  input  logic                    in_chan_b,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic signed [OUT_W-1:0] out_pulse_total,
  output logic signed [OUT_W-1:0] out_turns
);

  logic             use_x4_r;
  logic [PPT_W-1:0] ppt_r;
  logic [1:0]       last_phase_r, last_phase_nxt;
  logic             primed_r, primed_nxt;
  count_t           acc_r, acc_nxt;

  count_t           quo_r;
  logic [PPT_W-1:0] rem_r;
  logic             neg_r;

  logic signed [OUT_W-1:0] total_r;
  logic signed [OUT_W-1:0] turns_r;

  logic [1:0]       phase;
  logic [1:0]       diff;
  logic             up, down;
  logic [PPT_W-1:0] div_eff;
  logic [PPT_W:0]   partial;
  logic             ge;
  logic [PPT_W:0]   rem_sub;
  count_t           mag;
  count_t           quo_signed;

  assign phase = {in_chan_a, in_chan_b};
  assign diff  = last_phase_r ^ phase;

  // decode one step of the count
  always_comb begin
    up   = 1'b0;
    down = 1'b0;
    if (!use_x4_r) begin
      if ((last_phase_r == PHASE_BOTH && phase == PHASE_NONE) ||
          (last_phase_r == PHASE_NONE && phase == PHASE_BOTH)) begin
        up = 1'b1;
      end
      if ((last_phase_r == PHASE_A && phase == PHASE_B) ||
          (last_phase_r == PHASE_B && phase == PHASE_A)) begin
        down = 1'b1;
      end
    end else if (diff == PHASE_A || diff == PHASE_B) begin
      down = last_phase_r[0] ^ phase[1];
      up   = !(last_phase_r[0] ^ phase[1]);
    end
  end

  always_comb begin
    acc_nxt        = acc_r;
    last_phase_nxt = last_phase_r;
    primed_nxt     = primed_r;
    if (in_mode == MODE_CLEAR) begin
      acc_nxt = '0;
    end else if (!primed_r) begin
      last_phase_nxt = phase;
      primed_nxt     = 1'b1;
    end else if (!use_x4_r && !diff[1]) begin
      // channel A unchanged: hold
    end else begin
      if (up) begin
        acc_nxt = acc_r + 1'b1;
      end else if (down) begin
        acc_nxt = acc_r - 1'b1;
      end
      last_phase_nxt = phase;
    end
  end

  assign div_eff    = (ppt_r == '0) ? PPT_W'(1) : ppt_r;
  assign partial    = {rem_r, quo_r[COUNT_WIDTH-1]};
  assign ge         = (partial >= {1'b0, div_eff});
  assign rem_sub    = partial - {1'b0, div_eff};
  assign mag        = acc_r[COUNT_WIDTH-1] ? (~acc_r + 1'b1) : acc_r;
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_x4_r     <= 1'b1;
      ppt_r        <= PPT_W'(1);
      last_phase_r <= PHASE_NONE;
      primed_r     <= 1'b0;
      acc_r        <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_USE_X4) begin
        use_x4_r <= cfg_data[0];
      end
      if (cfg_write && cfg_index == REG_PPT) begin
        ppt_r <= cfg_data[PPT_W-1:0];
      end
      if (cmd.start) begin
        last_phase_r <= last_phase_nxt;
        primed_r     <= primed_nxt;
        acc_r        <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo_r <= mag;
      rem_r <= '0;
      neg_r <= acc_r[COUNT_WIDTH-1];
    end else if (cmd.step) begin
      quo_r <= {quo_r[COUNT_WIDTH-2:0], ge};
      rem_r <= ge ? rem_sub[PPT_W-1:0] : partial[PPT_W-1:0];
    end
    if (cmd.load) begin
      total_r <= OUT_W'(signed'(acc_r));
      turns_r <= OUT_W'(signed'(quo_signed));
    end
  end

  assign out_pulse_total = total_r;
  assign out_turns       = turns_r;

endmodule

FILE: hdl/qenc_checker.sv
// ----------------------------------------------------------------------------
// qenc_checker
// Port-level checks of the quadrature encoder counter, bound to the top.
// ----------------------------------------------------------------------------
module qenc_checker import qenc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] pulse_total,
  input logic signed [OUT_W-1:0] turns
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input ready right after a transfer");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !$rose(out_valid))
    else $error("result appeared one cycle after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pulse_total) && $stable(turns))
    else $error("result changed while stalled");

endmodule

bind quadrature_encoder_counter_core qenc_checker u_qenc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pulse_total (out_ch.pulse_total),
  .turns       (out_ch.turns)
);

FILE: test/qenc_count_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qenc_count_monitor
// Watches the sample, result and register channels of the quadrature encoder
// counter. Tracks the register settings, predicts the pulse count and the
// revolutions for every accepted item, and compares each result transfer
// field by field with the oldest prediction. Hands its failure count and the
// number of results still due to the testbench top.
// ----------------------------------------------------------------------------
module qenc_count_monitor import qenc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  qenc_in_if   in_mon,
  qenc_out_if  out_mon,
  qenc_cfg_if  cfg_mon,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic signed [OUT_W-1:0] pulse_total;
    logic signed [OUT_W-1:0] turns;
  } count_result_t;

  count_result_t    expected_counts[$];
  logic             x4_mode;
  logic [PPT_W-1:0] pulses_per_turn;
  logic [1:0]       prev_phase;
  logic             phase_seen;
  count_t           pulse_acc;
  int               fail_count = 0;

  function automatic count_result_t next_count(input logic mode, input logic [1:0] phase);
    logic [1:0]         flip;
    logic signed [63:0] wide;
    logic [63:0]        mag;
    logic [63:0]        divisor;
    logic [63:0]        quot;
    count_result_t      res;
    flip = prev_phase ^ phase;
    if (mode == MODE_CLEAR) begin
      pulse_acc = '0;
    end else if (!phase_seen) begin
      prev_phase = phase;
      phase_seen = 1'b1;
    end else if (!x4_mode && !flip[1]) begin
      // hold: no edge on channel A
    end else begin
      if (!x4_mode) begin
        if ((prev_phase == PHASE_BOTH && phase == PHASE_NONE) ||
            (prev_phase == PHASE_NONE && phase == PHASE_BOTH)) begin
          pulse_acc = pulse_acc + 1'b1;
        end else if ((prev_phase == PHASE_A && phase == PHASE_B) ||
                     (prev_phase == PHASE_B && phase == PHASE_A)) begin
          pulse_acc = pulse_acc - 1'b1;
        end
      end else if (flip != PHASE_NONE && flip != PHASE_BOTH) begin
        if (prev_phase[0] ^ phase[1]) begin
          pulse_acc = pulse_acc - 1'b1;
        end else begin
          pulse_acc = pulse_acc + 1'b1;
        end
      end
      prev_phase = phase;
    end
    wide    = $signed(pulse_acc);
    mag     = wide[63] ? (64'd0 - wide) : wide;
    divisor = (pulses_per_turn == '0) ? 64'd1 : 64'(pulses_per_turn);
    quot    = mag / divisor;
    if (wide[63]) begin
      quot = 64'd0 - quot;
    end
    res.pulse_total = wide[OUT_W-1:0];
    res.turns       = quot[OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    count_result_t want;
    if (!rst_n) begin
      x4_mode         = 1'b1;
      pulses_per_turn = 16'd1;
      prev_phase      = PHASE_NONE;
      phase_seen      = 1'b0;
      pulse_acc       = '0;
      expected_counts.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_USE_X4: x4_mode = cfg_mon.data[0];
          REG_PPT: pulses_per_turn = cfg_mon.data[PPT_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_counts.size() == 0) begin
          $error("result with none due: pulse_total %0d, turns %0d",
                 out_mon.pulse_total, out_mon.turns);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (out_mon.pulse_total !== want.pulse_total) begin
            $error("pulse_total: expected %0d, actual %0d", want.pulse_total,
                   out_mon.pulse_total);
            fail_count++;
          end
          if (out_mon.turns !== want.turns) begin
            $error("turns: expected %0d, actual %0d", want.turns, out_mon.turns);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_counts.push_back(next_count(in_mon.mode, {in_mon.chan_a, in_mon.chan_b}));
      end
    end
    mismatches  <= fail_count;
    outstanding <= expected_counts.size();
  end

endmodule

FILE: test/quadrature_encoder_counter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_encoder_counter_core_tb
// Drives the quadrature encoder counter with directed X4 and X2 sequences,
// then with random Gray-code walks mixed with noise and clear commands under
// several register settings, with random gaps and output stalls. Checking is
// done by qenc_count_monitor; this top gives the verdict.
// ----------------------------------------------------------------------------
module quadrature_encoder_counter_core_tb;
  import qenc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam int DRAIN_CYCLES = COUNT_WIDTH + 8;

  logic       clk;
  logic       rst_n;
  bit         quiet;
  int         mismatches;
  int         outstanding;
  logic [1:0] walk_phase;
  bit         walk_up;

  qenc_in_if  in_if();
  qenc_out_if out_if();
  qenc_cfg_if cfg_if();

  quadrature_encoder_counter_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  qenc_count_monitor i_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_item(input logic mode, input logic chan_a, input logic chan_b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.mode   <= mode;
    in_if.chan_a <= chan_a;
    in_if.chan_b <= chan_b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_item(MODE_CLEAR, 1'($urandom), 1'($urandom));
      end else if (roll < 14) begin
        walk_phase = 2'($urandom);
        send_item(MODE_SAMPLE, walk_phase[1], walk_phase[0]);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          walk_up = !walk_up;
        end
        if (walk_up) begin
          case (walk_phase)
            PHASE_NONE: walk_phase = PHASE_B;
            PHASE_B:    walk_phase = PHASE_BOTH;
            PHASE_BOTH: walk_phase = PHASE_A;
            default:    walk_phase = PHASE_NONE;
          endcase
        end else begin
          case (walk_phase)
            PHASE_NONE: walk_phase = PHASE_A;
            PHASE_A:    walk_phase = PHASE_BOTH;
            PHASE_BOTH: walk_phase = PHASE_B;
            default:    walk_phase = PHASE_NONE;
          endcase
        end
        send_item(MODE_SAMPLE, walk_phase[1], walk_phase[0]);
      end
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.mode   <= MODE_SAMPLE;
    in_if.chan_a <= 1'b0;
    in_if.chan_b <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_USE_X4;
    cfg_if.data  <= '0;
    quiet        = 1'b0;
    walk_phase   = PHASE_NONE;
    walk_up      = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // X4 at reset settings
    send_item(MODE_CLEAR, 1'b1, 1'b1);
    send_item(MODE_SAMPLE, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 1'b0, 1'b1);
    send_item(MODE_SAMPLE, 1'b1, 1'b1);
    send_item(MODE_SAMPLE, 1'b1, 1'b0);
    send_item(MODE_SAMPLE, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 1'b1, 1'b0);
    send_item(MODE_SAMPLE, 1'b1, 1'b1);
    send_item(MODE_SAMPLE, 1'b0, 1'b0);
    send_item(MODE_CLEAR, 1'b0, 1'b1);

    // X2
    write_reg(REG_USE_X4, 16'd0);
    write_reg(REG_PPT, 16'd3);
    send_item(MODE_SAMPLE, 1'b1, 1'b1);
    send_item(MODE_SAMPLE, 1'b1, 1'b0);
    send_item(MODE_SAMPLE, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 1'b0, 1'b1);
    send_item(MODE_SAMPLE, 1'b1, 1'b0);
    send_item(MODE_SAMPLE, 1'b0, 1'b1);
    send_item(MODE_SAMPLE, 1'b1, 1'b0);
    send_item(MODE_SAMPLE, 1'b1, 1'b1);
    send_item(MODE_SAMPLE, 1'b0, 1'b0);
    send_item(MODE_SAMPLE, 1'b1, 1'b1);
    send_item(MODE_CLEAR, 1'b1, 1'b0);

    write_reg(REG_USE_X4, 16'd1);
    write_reg(REG_PPT, 16'd0);
    random_phase(80);

    write_reg(REG_USE_X4, 16'd0);
    write_reg(REG_PPT, 16'hFFFF);
    random_phase(60);

    write_reg(REG_USE_X4, 16'hFFFE);
    write_reg(REG_PPT, 16'($urandom_range(2, 7)));
    write_reg(REG_SPARE, 16'($urandom));
    random_phase(80);

    write_reg(REG_USE_X4, 16'($urandom) | 16'd1);
    write_reg(REG_PPT, 16'($urandom_range(2, 12)));
    random_phase(100);

    write_reg(REG_USE_X4, 16'd1);
    write_reg(REG_PPT, 16'd1);
    quiet = 1'b1;
    random_phase(80);

    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
